// ===== design/mel_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mel_pkg
// Types, token kinds and keyword tables for the math expression lexer.
// ---------------------------------------------------------------------------
package mel_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int LINE_BITS_DEFAULT     = 16;
    localparam int MAX_RESULTS           = 5;

    localparam logic [4:0] K_END      = 5'd0;
    localparam logic [4:0] K_INT      = 5'd1;
    localparam logic [4:0] K_FLOAT    = 5'd2;
    localparam logic [4:0] K_RATIONAL = 5'd3;
    localparam logic [4:0] K_IDENT    = 5'd4;
    localparam logic [4:0] K_PLUS     = 5'd5;
    localparam logic [4:0] K_MINUS    = 5'd6;
    localparam logic [4:0] K_STAR     = 5'd7;
    localparam logic [4:0] K_SLASH    = 5'd8;
    localparam logic [4:0] K_CARET    = 5'd9;
    localparam logic [4:0] K_PERCENT  = 5'd10;
    localparam logic [4:0] K_BANG     = 5'd11;
    localparam logic [4:0] K_LPAREN   = 5'd12;
    localparam logic [4:0] K_RPAREN   = 5'd13;
    localparam logic [4:0] K_LBRACK   = 5'd14;
    localparam logic [4:0] K_RBRACK   = 5'd15;
    localparam logic [4:0] K_LBRACE   = 5'd16;
    localparam logic [4:0] K_RBRACE   = 5'd17;
    localparam logic [4:0] K_COMMA    = 5'd18;
    localparam logic [4:0] K_SEMI     = 5'd19;
    localparam logic [4:0] K_INTEGRAL = 5'd20;
    localparam logic [4:0] K_DERIV    = 5'd21;
    localparam logic [4:0] K_LIMIT    = 5'd22;
    localparam logic [4:0] K_SUM      = 5'd23;
    localparam logic [4:0] K_PRODUCT  = 5'd24;
    localparam logic [4:0] K_SQRT     = 5'd25;

    localparam logic [1:0] E_NONE   = 2'd0;
    localparam logic [1:0] E_NUMBER = 2'd1;
    localparam logic [1:0] E_CHAR   = 2'd2;

    localparam logic [7:0] KW_TEXT [0:5][0:3] = '{
        '{8'h69, 8'h6E, 8'h74, 8'h00},
        '{8'h64, 8'h69, 8'h66, 8'h66},
        '{8'h6C, 8'h69, 8'h6D, 8'h00},
        '{8'h73, 8'h75, 8'h6D, 8'h00},
        '{8'h70, 8'h72, 8'h6F, 8'h64},
        '{8'h73, 8'h71, 8'h72, 8'h74}
    };
    localparam logic [2:0] KW_LEN [0:5] = '{3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4};
    localparam logic [4:0] KW_KIND [0:5] = '{K_INTEGRAL, K_DERIV, K_LIMIT,
                                             K_SUM, K_PRODUCT, K_SQRT};

    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_present;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [1:0]  error_code;
        logic        final_result;
    } token_t;

    function automatic logic [4:0] op_kind(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h5E:   k = K_CARET;
            8'h25:   k = K_PERCENT;
            8'h21:   k = K_BANG;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h2C:   k = K_COMMA;
            8'h3B:   k = K_SEMI;
            default: k = K_END;
        endcase
        return k;
    endfunction

endpackage

// ===== design/math_expression_lexer_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// math_expression_lexer_unit
// Streaming lexer that turns expression bytes into tokens.
// ---------------------------------------------------------------------------
// Bytes enter on the s_ channel, one request per byte, with byte_present
// and end_of_input flags; tokens leave on the m_ channel. Each accepted
// request is lexed in the cycle it is accepted and yields zero to five
// tokens, which are written into a five-entry result buffer and drained
// one per cycle while m_ready is high, from the cycle after acceptance.
// A request yielding n tokens holds the output until all n are taken;
// with m_ready high, requests yielding none or one are taken every
// cycle, as a new request is accepted while the last token is taken.
// When the receiver stalls, the buffer holds and s_ready stays low while
// any token is waiting that is not taken in that cycle. Reset returns the
// lexer to line 1, column 1, offset 0, and empties the buffer.
// ---------------------------------------------------------------------------
module math_expression_lexer_unit #(
    parameter int POSITION_BITS = mel_pkg::POSITION_BITS_DEFAULT,
    parameter int LINE_BITS     = mel_pkg::LINE_BITS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mel_pkg::in_item_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output mel_pkg::token_t  m_data
);

    localparam int P = POSITION_BITS;
    localparam int L = LINE_BITS;
    localparam int W = ((P > L) ? P : L) + 1;

    typedef enum logic [3:0] {
        M_IDLE, M_E2, M_E2_88, M_CE, M_CF, M_DFIRST, M_DSLASH,
        M_IDENT, M_INT, M_DOT, M_FRAC, M_NSLASH, M_DENZERO, M_DEN
    } mode_t;

    mode_t        mode_reg, mode_next;
    logic [P-1:0] pos_reg, pos_next;
    logic [L-1:0] line_reg, line_next;
    logic [L-1:0] col_reg, col_next;
    logic [P-1:0] pstart_reg, pstart_next;
    logic [L-1:0] pline_reg, pline_next;
    logic [L-1:0] pcol_reg, pcol_next;
    logic [P-1:0] held_reg, held_next;
    logic [5:0]   cand_reg, cand_next;
    logic [P-1:0] nend_reg, nend_next;
    logic         err_reg, err_next;

    mel_pkg::token_t res [0:4];
    logic [2:0]      res_n;
    mel_pkg::token_t buf_reg [0:4];
    logic [2:0]      count_reg;
    logic [2:0]      rd_reg;
    logic            s_fire;
    logic            m_fire;

    function automatic logic [P-1:0] sat_pos(input logic [W-1:0] s);
        logic [W-1:0] m;
        m = W'({P{1'b1}});
        return (s > m) ? {P{1'b1}} : s[P-1:0];
    endfunction

    function automatic logic [L-1:0] sat_line(input logic [W-1:0] s);
        logic [W-1:0] m;
        m = W'({L{1'b1}});
        return (s > m) ? {L{1'b1}} : s[L-1:0];
    endfunction

    function automatic mel_pkg::token_t mk(input logic [4:0] kind, input logic [P-1:0] start,
                                           input logic [P-1:0] len, input logic [L-1:0] ln,
                                           input logic [L-1:0] cl, input logic [1:0] ec,
                                           input logic fin);
        mel_pkg::token_t t;
        logic [31:0] a, b, c, d;
        a = 32'(start);
        b = 32'(len);
        c = 32'(ln);
        d = 32'(cl);
        t.token_kind   = kind;
        t.token_start  = a[15:0];
        t.token_length = b[15:0];
        t.start_line   = c[15:0];
        t.start_column = d[15:0];
        t.error_code   = ec;
        t.final_result = fin;
        return t;
    endfunction

    function automatic logic [5:0] cand_update(input logic [5:0] cand, input logic [P-1:0] idx,
                                               input logic [7:0] b);
        logic [5:0] r;
        r = '0;
        for (int k = 0; k < 6; k++) begin
            if (cand[k] && idx < P'(mel_pkg::KW_LEN[k]) &&
                mel_pkg::KW_TEXT[k][idx[1:0]] == b) begin
                r[k] = 1'b1;
            end
        end
        return r;
    endfunction

    always_comb begin
        logic [7:0] b;
        logic       done;
        logic       dig;
        logic       alpha;
        logic [4:0] kind;
        logic [W-1:0] skip;

        mode_next   = mode_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        pstart_next = pstart_reg;
        pline_next  = pline_reg;
        pcol_next   = pcol_reg;
        held_next   = held_reg;
        cand_next   = cand_reg;
        nend_next   = nend_reg;
        err_next    = err_reg;
        res_n       = '0;
        for (int i = 0; i < 5; i++) begin
            res[i] = '0;
        end
        b     = s_data.byte_value;
        dig   = b inside {[8'h30:8'h39]};
        alpha = b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
        kind  = mel_pkg::K_IDENT;
        skip  = '0;
        done  = 1'b0;

        if (s_data.byte_present && !err_reg) begin
            for (int it = 0; it < 3; it++) begin
                if (!done) begin
                    done = 1'b1;
                    case (mode_next)
                        M_IDLE: begin
                            if (b inside {8'h20, 8'h09, 8'h0D}) begin
                                pos_next = sat_pos(W'(pos_next) + W'(1));
                                col_next = sat_line(W'(col_next) + W'(1));
                            end else if (b == 8'h0A) begin
                                pos_next  = sat_pos(W'(pos_next) + W'(1));
                                line_next = sat_line(W'(line_next) + W'(1));
                                col_next  = L'(1);
                            end else if (b inside {8'hE2, 8'hCE, 8'hCF}) begin
                                pstart_next = pos_next;
                                pline_next  = line_next;
                                pcol_next   = col_next;
                                mode_next   = (b == 8'hE2) ? M_E2 :
                                              ((b == 8'hCE) ? M_CE : M_CF);
                                pos_next    = sat_pos(W'(pos_next) + W'(1));
                            end else if (mel_pkg::op_kind(b) != mel_pkg::K_END) begin
                                res[res_n] = mk(mel_pkg::op_kind(b), pos_next, P'(1),
                                                line_next, col_next, mel_pkg::E_NONE, 1'b0);
                                res_n = res_n + 3'd1;
                                pos_next = sat_pos(W'(pos_next) + W'(1));
                                col_next = sat_line(W'(col_next) + W'(1));
                            end else if (dig || alpha || b == 8'h5F) begin
                                pstart_next = pos_next;
                                pline_next  = line_next;
                                pcol_next   = col_next;
                                held_next   = P'(1);
                                cand_next   = cand_update(6'h3F, '0, b);
                                mode_next   = dig ? M_INT : ((b == 8'h64) ? M_DFIRST : M_IDENT);
                                pos_next    = sat_pos(W'(pos_next) + W'(1));
                                col_next    = sat_line(W'(col_next) + W'(1));
                            end else begin
                                res[res_n] = mk(mel_pkg::K_END, pos_next, '0, line_next,
                                                col_next, mel_pkg::E_CHAR, 1'b1);
                                res_n = res_n + 3'd1;
                                err_next  = 1'b1;
                                mode_next = M_IDLE;
                            end
                        end
                        M_E2, M_E2_88, M_CE, M_CF: begin
                            kind = mel_pkg::K_END;
                            if (mode_next == M_E2 && b == 8'h88) begin
                                mode_next = M_E2_88;
                                pos_next  = sat_pos(W'(pos_next) + W'(1));
                            end else begin
                                if (mode_next == M_E2_88) begin
                                    if (b == 8'hAB) kind = mel_pkg::K_INTEGRAL;
                                    else if (b == 8'h9A) kind = mel_pkg::K_SQRT;
                                    else if (b == 8'h9E) kind = mel_pkg::K_IDENT;
                                end else if (mode_next == M_CE) begin
                                    if (b == 8'hA3) kind = mel_pkg::K_SUM;
                                    else if (b == 8'hA0) kind = mel_pkg::K_PRODUCT;
                                end else if (mode_next == M_CF) begin
                                    if (b == 8'h80) kind = mel_pkg::K_IDENT;
                                end
                                if (kind != mel_pkg::K_END) begin
                                    res[res_n] = mk(kind, pstart_next,
                                                    (mode_next == M_E2_88) ? P'(3) : P'(2),
                                                    pline_next, pcol_next,
                                                    mel_pkg::E_NONE, 1'b0);
                                    res_n = res_n + 3'd1;
                                    pos_next = sat_pos(W'(pos_next) + W'(1));
                                    col_next = sat_line(W'(col_next) + W'(1));
                                end else begin
                                    res[res_n] = mk(mel_pkg::K_END, pstart_next, '0,
                                                    pline_next, pcol_next,
                                                    mel_pkg::E_CHAR, 1'b1);
                                    res_n = res_n + 3'd1;
                                    err_next = 1'b1;
                                end
                                mode_next = M_IDLE;
                            end
                        end
                        M_DFIRST: begin
                            if (b == 8'h2F) begin
                                held_next = P'(2);
                                mode_next = M_DSLASH;
                                pos_next  = sat_pos(W'(pos_next) + W'(1));
                                col_next  = sat_line(W'(col_next) + W'(1));
                            end else begin
                                mode_next = M_IDENT;
                                done      = 1'b0;
                            end
                        end
                        M_DSLASH: begin
                            if (b == 8'h64) begin
                                res[res_n] = mk(mel_pkg::K_DERIV, pstart_next, P'(3),
                                                pline_next, pcol_next, mel_pkg::E_NONE, 1'b0);
                                res_n = res_n + 3'd1;
                                pos_next = sat_pos(W'(pos_next) + W'(1));
                                col_next = sat_line(W'(col_next) + W'(1));
                            end else begin
                                res[res_n] = mk(mel_pkg::K_IDENT, pstart_next, P'(1),
                                                pline_next, pcol_next, mel_pkg::E_NONE, 1'b0);
                                res_n = res_n + 3'd1;
                                res[res_n] = mk(mel_pkg::K_SLASH,
                                                sat_pos(W'(pstart_next) + W'(1)), P'(1),
                                                pline_next, sat_line(W'(pcol_next) + W'(1)),
                                                mel_pkg::E_NONE, 1'b0);
                                res_n = res_n + 3'd1;
                                done  = 1'b0;
                            end
                            mode_next = M_IDLE;
                        end
                        M_IDENT: begin
                            if (alpha || dig || b == 8'h5F) begin
                                cand_next = cand_update(cand_next, held_next, b);
                                held_next = sat_pos(W'(held_next) + W'(1));
                                pos_next  = sat_pos(W'(pos_next) + W'(1));
                                col_next  = sat_line(W'(col_next) + W'(1));
                            end else begin
                                kind = mel_pkg::K_IDENT;
                                for (int k = 0; k < 6; k++) begin
                                    if (cand_next[k] && held_next == P'(mel_pkg::KW_LEN[k])) begin
                                        kind = mel_pkg::KW_KIND[k];
                                    end
                                end
                                res[res_n] = mk(kind, pstart_next, held_next, pline_next,
                                                pcol_next, mel_pkg::E_NONE, 1'b0);
                                res_n = res_n + 3'd1;
                                mode_next = M_IDLE;
                                done      = 1'b0;
                            end
                        end
                        M_INT: begin
                            if (dig) begin
                                held_next = sat_pos(W'(held_next) + W'(1));
                                pos_next  = sat_pos(W'(pos_next) + W'(1));
                                col_next  = sat_line(W'(col_next) + W'(1));
                            end else if (b == 8'h2E || b == 8'h2F) begin
                                if (b == 8'h2F) nend_next = held_next;
                                held_next = sat_pos(W'(held_next) + W'(1));
                                mode_next = (b == 8'h2E) ? M_DOT : M_NSLASH;
                                pos_next  = sat_pos(W'(pos_next) + W'(1));
                                col_next  = sat_line(W'(col_next) + W'(1));
                            end else begin
                                res[res_n] = mk(mel_pkg::K_INT, pstart_next, held_next,
                                                pline_next, pcol_next, mel_pkg::E_NONE, 1'b0);
                                res_n = res_n + 3'd1;
                                mode_next = M_IDLE;
                                done      = 1'b0;
                            end
                        end
                        M_DOT: begin
                            if (dig) begin
                                held_next = sat_pos(W'(held_next) + W'(1));
                                mode_next = M_FRAC;
                                pos_next  = sat_pos(W'(pos_next) + W'(1));
                                col_next  = sat_line(W'(col_next) + W'(1));
                            end else begin
                                res[res_n] = mk(mel_pkg::K_END, pstart_next, '0, pline_next,
                                                pcol_next, mel_pkg::E_NUMBER, 1'b1);
                                res_n = res_n + 3'd1;
                                err_next  = 1'b1;
                                mode_next = M_IDLE;
                            end
                        end
                        M_FRAC, M_DEN: begin
                            if (dig) begin
                                held_next = sat_pos(W'(held_next) + W'(1));
                                pos_next  = sat_pos(W'(pos_next) + W'(1));
                                col_next  = sat_line(W'(col_next) + W'(1));
                            end else begin
                                res[res_n] = mk((mode_next == M_FRAC) ? mel_pkg::K_FLOAT :
                                                mel_pkg::K_RATIONAL, pstart_next, held_next,
                                                pline_next, pcol_next, mel_pkg::E_NONE, 1'b0);
                                res_n = res_n + 3'd1;
                                mode_next = M_IDLE;
                                done      = 1'b0;
                            end
                        end
                        M_NSLASH, M_DENZERO: begin
                            if (dig) begin
                                held_next = sat_pos(W'(held_next) + W'(1));
                                mode_next = (mode_next == M_NSLASH && b == 8'h30) ?
                                            M_DENZERO : M_DEN;
                                pos_next  = sat_pos(W'(pos_next) + W'(1));
                                col_next  = sat_line(W'(col_next) + W'(1));
                            end else begin
                                res[res_n] = mk(mel_pkg::K_INT, pstart_next, nend_next,
                                                pline_next, pcol_next, mel_pkg::E_NONE, 1'b0);
                                res_n = res_n + 3'd1;
                                res[res_n] = mk(mel_pkg::K_SLASH,
                                                sat_pos(W'(pstart_next) + W'(nend_next)),
                                                P'(1), pline_next,
                                                sat_line(W'(pcol_next) + W'(nend_next)),
                                                mel_pkg::E_NONE, 1'b0);
                                res_n = res_n + 3'd1;
                                if (mode_next == M_DENZERO) begin
                                    skip        = W'(nend_next) + W'(1);
                                    pstart_next = sat_pos(W'(pstart_next) + skip);
                                    pcol_next   = sat_line(W'(pcol_next) + skip);
                                    held_next   = P'(1);
                                    mode_next   = M_INT;
                                end else begin
                                    mode_next = M_IDLE;
                                end
                                done = 1'b0;
                            end
                        end
                        default: begin
                            mode_next = M_IDLE;
                            done      = 1'b0;
                        end
                    endcase
                end
            end
        end

        if (s_data.end_of_input) begin
            if (!err_next) begin
                case (mode_next)
                    M_E2, M_E2_88, M_CE, M_CF, M_DOT: begin
                        res[res_n] = mk(mel_pkg::K_END, pstart_next, '0, pline_next, pcol_next,
                                        (mode_next == M_DOT) ? mel_pkg::E_NUMBER :
                                        mel_pkg::E_CHAR, 1'b1);
                        res_n = res_n + 3'd1;
                        err_next = 1'b1;
                    end
                    M_DFIRST, M_IDENT: begin
                        kind = mel_pkg::K_IDENT;
                        for (int k = 0; k < 6; k++) begin
                            if (cand_next[k] && held_next == P'(mel_pkg::KW_LEN[k])) begin
                                kind = mel_pkg::KW_KIND[k];
                            end
                        end
                        res[res_n] = mk(kind, pstart_next, held_next, pline_next, pcol_next,
                                        mel_pkg::E_NONE, 1'b0);
                        res_n = res_n + 3'd1;
                    end
                    M_DSLASH: begin
                        res[res_n] = mk(mel_pkg::K_IDENT, pstart_next, P'(1), pline_next,
                                        pcol_next, mel_pkg::E_NONE, 1'b0);
                        res_n = res_n + 3'd1;
                        res[res_n] = mk(mel_pkg::K_SLASH, sat_pos(W'(pstart_next) + W'(1)),
                                        P'(1), pline_next, sat_line(W'(pcol_next) + W'(1)),
                                        mel_pkg::E_NONE, 1'b0);
                        res_n = res_n + 3'd1;
                    end
                    M_INT, M_FRAC, M_DEN: begin
                        res[res_n] = mk((mode_next == M_INT) ? mel_pkg::K_INT :
                                        ((mode_next == M_FRAC) ? mel_pkg::K_FLOAT :
                                        mel_pkg::K_RATIONAL), pstart_next, held_next,
                                        pline_next, pcol_next, mel_pkg::E_NONE, 1'b0);
                        res_n = res_n + 3'd1;
                    end
                    M_NSLASH, M_DENZERO: begin
                        res[res_n] = mk(mel_pkg::K_INT, pstart_next, nend_next, pline_next,
                                        pcol_next, mel_pkg::E_NONE, 1'b0);
                        res_n = res_n + 3'd1;
                        res[res_n] = mk(mel_pkg::K_SLASH,
                                        sat_pos(W'(pstart_next) + W'(nend_next)), P'(1),
                                        pline_next, sat_line(W'(pcol_next) + W'(nend_next)),
                                        mel_pkg::E_NONE, 1'b0);
                        res_n = res_n + 3'd1;
                        if (mode_next == M_DENZERO) begin
                            skip = W'(nend_next) + W'(1);
                            res[res_n] = mk(mel_pkg::K_INT, sat_pos(W'(pstart_next) + skip),
                                            P'(1), pline_next, sat_line(W'(pcol_next) + skip),
                                            mel_pkg::E_NONE, 1'b0);
                            res_n = res_n + 3'd1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (!err_next) begin
                    res[res_n] = mk(mel_pkg::K_END, pos_next, '0, line_next, col_next,
                                    mel_pkg::E_NONE, 1'b1);
                    res_n = res_n + 3'd1;
                end
            end
            mode_next   = M_IDLE;
            pos_next    = '0;
            line_next   = L'(1);
            col_next    = L'(1);
            pstart_next = '0;
            pline_next  = L'(1);
            pcol_next   = L'(1);
            held_next   = '0;
            cand_next   = 6'h3F;
            nend_next   = '0;
            err_next    = 1'b0;
        end
    end

    assign m_valid = (rd_reg != count_reg);
    assign s_ready = !m_valid || (m_ready && (rd_reg + 3'd1 == count_reg));
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign m_data  = buf_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            line_reg   <= L'(1);
            col_reg    <= L'(1);
            pstart_reg <= '0;
            pline_reg  <= L'(1);
            pcol_reg   <= L'(1);
            held_reg   <= '0;
            cand_reg   <= 6'h3F;
            nend_reg   <= '0;
            err_reg    <= 1'b0;
            count_reg  <= '0;
            rd_reg     <= '0;
        end else if (s_fire) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            pstart_reg <= pstart_next;
            pline_reg  <= pline_next;
            pcol_reg   <= pcol_next;
            held_reg   <= held_next;
            cand_reg   <= cand_next;
            nend_reg   <= nend_next;
            err_reg    <= err_next;
            count_reg  <= res_n;
            rd_reg     <= '0;
        end else if (m_fire) begin
            rd_reg <= rd_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < 5; i++) begin
                buf_reg[i] <= res[i];
            end
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= 3'(mel_pkg::MAX_RESULTS)) && (rd_reg <= count_reg))
        else $error("result buffer index out of range");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && res_n != 3'd0) |=> m_valid)
        else $error("tokens of an accepted request not presented");

    a_error_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> (mode_reg == M_IDLE))
        else $error("lexer not idle after error");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.end_of_input) |=> (!err_reg && pos_reg == '0))
        else $error("end of input did not restart the lexer");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the math expression lexer unit.
// ---------------------------------------------------------------------------
// Directed expressions cover symbols, keywords, numbers, errors and blank
// space, then random well-formed expressions mixed with noise. A scan
// predictor computes the expected tokens of every accepted request and the
// monitor compares each token field by field, with random stalls on both
// sides.
// ---------------------------------------------------------------------------
module testbench;

    typedef enum logic [3:0] {
        SC_IDLE, SC_E2, SC_E2_88, SC_CE, SC_CF, SC_DFIRST, SC_DSLASH,
        SC_IDENT, SC_INT, SC_DOT, SC_FRAC, SC_NSLASH, SC_DENZERO, SC_DEN
    } scan_t;

    localparam int POS_MAX     = 65535;
    localparam int WATCHDOG    = 5000;
    localparam int ITEMS       = 130;
    localparam int HOLD_CYCLES = 60;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    mel_pkg::in_item_t s_data;
    logic              m_valid;
    logic              m_ready;
    mel_pkg::token_t   m_data;

    mel_pkg::in_item_t pending_bytes[$];
    mel_pkg::token_t   expected_tokens[$];
    int       mismatches;
    int       tokens_seen;
    int       idle_cycles;
    int       items_queued;
    bit       hold_receiver;
    bit       pause_sender;
    bit       in_taken;

    scan_t    lx_mode;
    int       lx_pos, lx_line, lx_col, lx_pstart, lx_pline, lx_pcol, lx_held;
    int       lx_numend;
    bit [5:0] lx_cand;
    bit       lx_err;

    math_expression_lexer_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    function automatic int sat(input int a);
        return (a > POS_MAX) ? POS_MAX : a;
    endfunction

    function automatic bit is_dig(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alp(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic [4:0] operator_kind(input logic [7:0] b);
        case (b)
            "+": return mel_pkg::K_PLUS;      "-": return mel_pkg::K_MINUS;
            "*": return mel_pkg::K_STAR;      "/": return mel_pkg::K_SLASH;
            "^": return mel_pkg::K_CARET;     "%": return mel_pkg::K_PERCENT;
            "!": return mel_pkg::K_BANG;      "(": return mel_pkg::K_LPAREN;
            ")": return mel_pkg::K_RPAREN;    "[": return mel_pkg::K_LBRACK;
            "]": return mel_pkg::K_RBRACK;    "{": return mel_pkg::K_LBRACE;
            "}": return mel_pkg::K_RBRACE;    ",": return mel_pkg::K_COMMA;
            ";": return mel_pkg::K_SEMI;
            default: return mel_pkg::K_END;
        endcase
    endfunction

    function automatic bit [5:0] keyword_match(input bit [5:0] cand, input int idx,
                                               input logic [7:0] b);
        string    words[6];
        bit [5:0] r;
        words = '{"int", "diff", "lim", "sum", "prod", "sqrt"};
        r = '0;
        for (int k = 0; k < 6; k++)
            if (cand[k] && idx < words[k].len() && words[k][idx] == b)
                r[k] = 1'b1;
        return r;
    endfunction

    task automatic add_expected(input logic [4:0] kind, input int start, input int len,
                                input int line, input int col, input logic [1:0] err,
                                input logic fin);
        mel_pkg::token_t t;
        t.token_kind   = kind;
        t.token_start  = start[15:0];
        t.token_length = len[15:0];
        t.start_line   = line[15:0];
        t.start_column = col[15:0];
        t.error_code   = err;
        t.final_result = fin;
        expected_tokens = {expected_tokens, t};
    endtask

    task automatic lexer_clear();
        lx_mode = SC_IDLE; lx_pos = 0; lx_line = 1; lx_col = 1;
        lx_pstart = 0; lx_pline = 1; lx_pcol = 1; lx_held = 0;
        lx_cand = '1; lx_numend = 0; lx_err = 0;
    endtask

    task automatic raise_error(input logic [1:0] code, input int s, input int l,
                               input int c);
        add_expected(mel_pkg::K_END, s, 0, l, c, code, 1'b1);
        lx_err = 1;
        lx_mode = SC_IDLE;
    endtask

    task automatic step_ascii();
        lx_pos = sat(lx_pos + 1);
        lx_col = sat(lx_col + 1);
    endtask

    task automatic emit_identifier();
        string       words[6];
        logic [4:0]  kinds[6];
        logic [4:0]  kind;
        words = '{"int", "diff", "lim", "sum", "prod", "sqrt"};
        kinds = '{mel_pkg::K_INTEGRAL, mel_pkg::K_DERIV, mel_pkg::K_LIMIT,
                  mel_pkg::K_SUM, mel_pkg::K_PRODUCT, mel_pkg::K_SQRT};
        kind = mel_pkg::K_IDENT;
        for (int k = 0; k < 6; k++)
            if (lx_cand[k] && lx_held == words[k].len())
                kind = kinds[k];
        add_expected(kind, lx_pstart, lx_held, lx_pline, lx_pcol, mel_pkg::E_NONE, 1'b0);
    endtask

    task automatic emit_numerator_slash();
        add_expected(mel_pkg::K_INT, lx_pstart, lx_numend, lx_pline, lx_pcol,
                     mel_pkg::E_NONE, 1'b0);
        add_expected(mel_pkg::K_SLASH, sat(lx_pstart + lx_numend), 1, lx_pline,
                     sat(lx_pcol + lx_numend), mel_pkg::E_NONE, 1'b0);
    endtask

    task automatic restart_at_zero();
        lx_pstart = sat(lx_pstart + lx_numend + 1);
        lx_pcol   = sat(lx_pcol + lx_numend + 1);
        lx_held   = 1;
        lx_mode   = SC_INT;
    endtask

    task automatic symbol_done(input logic [4:0] kind, input int len);
        add_expected(kind, lx_pstart, len, lx_pline, lx_pcol, mel_pkg::E_NONE, 1'b0);
        step_ascii();
        lx_mode = SC_IDLE;
    endtask

    task automatic lex_byte(input logic [7:0] b);
        bit again;
        logic [4:0] k;
        again = 1;
        while (again) begin
            again = 0;
            case (lx_mode)
                SC_IDLE: begin
                    k = operator_kind(b);
                    if (b == " " || b == 8'h09 || b == 8'h0D) begin
                        step_ascii();
                    end else if (b == 8'h0A) begin
                        lx_pos = sat(lx_pos + 1);
                        lx_line = sat(lx_line + 1);
                        lx_col = 1;
                    end else if (b == 8'hE2 || b == 8'hCE || b == 8'hCF) begin
                        lx_pstart = lx_pos; lx_pline = lx_line; lx_pcol = lx_col;
                        lx_mode = (b == 8'hE2) ? SC_E2 : (b == 8'hCE) ? SC_CE : SC_CF;
                        lx_pos = sat(lx_pos + 1);
                    end else if (k != mel_pkg::K_END) begin
                        add_expected(k, lx_pos, 1, lx_line, lx_col, mel_pkg::E_NONE, 1'b0);
                        step_ascii();
                    end else if (is_dig(b) || is_alp(b) || b == "_") begin
                        lx_pstart = lx_pos; lx_pline = lx_line; lx_pcol = lx_col;
                        lx_held = 1;
                        lx_cand = keyword_match(6'h3F, 0, b);
                        lx_mode = is_dig(b) ? SC_INT : (b == "d") ? SC_DFIRST : SC_IDENT;
                        step_ascii();
                    end else begin
                        raise_error(mel_pkg::E_CHAR, lx_pos, lx_line, lx_col);
                    end
                end
                SC_E2: begin
                    if (b == 8'h88) begin
                        lx_mode = SC_E2_88;
                        lx_pos = sat(lx_pos + 1);
                    end else raise_error(mel_pkg::E_CHAR, lx_pstart, lx_pline, lx_pcol);
                end
                SC_E2_88: begin
                    if (b == 8'hAB) symbol_done(mel_pkg::K_INTEGRAL, 3);
                    else if (b == 8'h9A) symbol_done(mel_pkg::K_SQRT, 3);
                    else if (b == 8'h9E) symbol_done(mel_pkg::K_IDENT, 3);
                    else raise_error(mel_pkg::E_CHAR, lx_pstart, lx_pline, lx_pcol);
                end
                SC_CE: begin
                    if (b == 8'hA3) symbol_done(mel_pkg::K_SUM, 2);
                    else if (b == 8'hA0) symbol_done(mel_pkg::K_PRODUCT, 2);
                    else raise_error(mel_pkg::E_CHAR, lx_pstart, lx_pline, lx_pcol);
                end
                SC_CF: begin
                    if (b == 8'h80) symbol_done(mel_pkg::K_IDENT, 2);
                    else raise_error(mel_pkg::E_CHAR, lx_pstart, lx_pline, lx_pcol);
                end
                SC_DFIRST: begin
                    if (b == "/") begin
                        lx_held = 2; lx_mode = SC_DSLASH; step_ascii();
                    end else begin
                        lx_mode = SC_IDENT; again = 1;
                    end
                end
                SC_DSLASH: begin
                    if (b == "d") begin
                        add_expected(mel_pkg::K_DERIV, lx_pstart, 3, lx_pline, lx_pcol,
                                     mel_pkg::E_NONE, 1'b0);
                        step_ascii();
                        lx_mode = SC_IDLE;
                    end else begin
                        add_expected(mel_pkg::K_IDENT, lx_pstart, 1, lx_pline, lx_pcol,
                                     mel_pkg::E_NONE, 1'b0);
                        add_expected(mel_pkg::K_SLASH, sat(lx_pstart + 1), 1, lx_pline,
                                     sat(lx_pcol + 1), mel_pkg::E_NONE, 1'b0);
                        lx_mode = SC_IDLE; again = 1;
                    end
                end
                SC_IDENT: begin
                    if (is_alp(b) || is_dig(b) || b == "_") begin
                        lx_cand = keyword_match(lx_cand, lx_held, b);
                        lx_held = sat(lx_held + 1);
                        step_ascii();
                    end else begin
                        emit_identifier(); lx_mode = SC_IDLE; again = 1;
                    end
                end
                SC_INT: begin
                    if (is_dig(b)) begin
                        lx_held = sat(lx_held + 1); step_ascii();
                    end else if (b == "." || b == "/") begin
                        if (b == "/") lx_numend = lx_held;
                        lx_held = sat(lx_held + 1);
                        lx_mode = (b == ".") ? SC_DOT : SC_NSLASH;
                        step_ascii();
                    end else begin
                        add_expected(mel_pkg::K_INT, lx_pstart, lx_held, lx_pline, lx_pcol,
                                     mel_pkg::E_NONE, 1'b0);
                        lx_mode = SC_IDLE; again = 1;
                    end
                end
                SC_DOT: begin
                    if (is_dig(b)) begin
                        lx_held = sat(lx_held + 1); lx_mode = SC_FRAC; step_ascii();
                    end else raise_error(mel_pkg::E_NUMBER, lx_pstart, lx_pline, lx_pcol);
                end
                SC_FRAC, SC_DEN: begin
                    if (is_dig(b)) begin
                        lx_held = sat(lx_held + 1); step_ascii();
                    end else begin
                        add_expected((lx_mode == SC_FRAC) ? mel_pkg::K_FLOAT :
                                     mel_pkg::K_RATIONAL, lx_pstart, lx_held, lx_pline,
                                     lx_pcol, mel_pkg::E_NONE, 1'b0);
                        lx_mode = SC_IDLE; again = 1;
                    end
                end
                SC_NSLASH: begin
                    if (is_dig(b)) begin
                        lx_held = sat(lx_held + 1);
                        lx_mode = (b == "0") ? SC_DENZERO : SC_DEN;
                        step_ascii();
                    end else begin
                        emit_numerator_slash(); lx_mode = SC_IDLE; again = 1;
                    end
                end
                SC_DENZERO: begin
                    if (is_dig(b)) begin
                        lx_held = sat(lx_held + 1); lx_mode = SC_DEN; step_ascii();
                    end else begin
                        emit_numerator_slash(); restart_at_zero(); again = 1;
                    end
                end
                default: begin
                    lx_mode = SC_IDLE; again = 1;
                end
            endcase
        end
    endtask

    task automatic lex_flush();
        case (lx_mode)
            SC_E2, SC_E2_88, SC_CE, SC_CF: begin
                raise_error(mel_pkg::E_CHAR, lx_pstart, lx_pline, lx_pcol);
                return;
            end
            SC_DOT: begin
                raise_error(mel_pkg::E_NUMBER, lx_pstart, lx_pline, lx_pcol);
                return;
            end
            SC_DFIRST, SC_IDENT: emit_identifier();
            SC_DSLASH: begin
                add_expected(mel_pkg::K_IDENT, lx_pstart, 1, lx_pline, lx_pcol,
                             mel_pkg::E_NONE, 1'b0);
                add_expected(mel_pkg::K_SLASH, sat(lx_pstart + 1), 1, lx_pline,
                             sat(lx_pcol + 1), mel_pkg::E_NONE, 1'b0);
            end
            SC_INT: add_expected(mel_pkg::K_INT, lx_pstart, lx_held, lx_pline, lx_pcol,
                                 mel_pkg::E_NONE, 1'b0);
            SC_FRAC: add_expected(mel_pkg::K_FLOAT, lx_pstart, lx_held, lx_pline, lx_pcol,
                                  mel_pkg::E_NONE, 1'b0);
            SC_DEN: add_expected(mel_pkg::K_RATIONAL, lx_pstart, lx_held, lx_pline, lx_pcol,
                                 mel_pkg::E_NONE, 1'b0);
            SC_NSLASH: emit_numerator_slash();
            SC_DENZERO: begin
                emit_numerator_slash();
                restart_at_zero();
                add_expected(mel_pkg::K_INT, lx_pstart, lx_held, lx_pline, lx_pcol,
                             mel_pkg::E_NONE, 1'b0);
            end
            default: ;
        endcase
        lx_mode = SC_IDLE;
        add_expected(mel_pkg::K_END, lx_pos, 0, lx_line, lx_col, mel_pkg::E_NONE, 1'b1);
    endtask

    task automatic predict_tokens(input mel_pkg::in_item_t it);
        if (it.byte_present && !lx_err) lex_byte(it.byte_value);
        if (it.end_of_input) begin
            if (!lx_err) lex_flush();
            lexer_clear();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH token %0d %s: got %0d expected %0d", tokens_seen, what, got, want);
    endtask

    task automatic queue_byte(input logic [7:0] b, input bit present, input bit last);
        mel_pkg::in_item_t it;
        it.byte_value = b;
        it.byte_present = present;
        it.end_of_input = last;
        pending_bytes = {pending_bytes, it};
        items_queued++;
    endtask

    task automatic queue_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], 1'b1, close && i == s.len() - 1);
    endtask

    function automatic string random_word();
        string pool[16];
        pool = '{"int", "diff", "lim", "sum", "prod", "sqrt", "x", "d/dx", "12",
                 "3.25", "7/0", "7/05", "22/7", "ab_9", "d", "Zq"};
        return pool[$urandom_range(0, 15)];
    endfunction

    function automatic string random_glue();
        string pool[12];
        pool = '{" ", "+", "-", "*", "/", "^", "(", ")", "\n", "\t", ",", "\xE2\x88\xAB"};
        return pool[$urandom_range(0, 11)];
    endfunction

    // Sender: bursts of requests separated by random gaps.
    int burst_left;
    int gap_left;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!s_valid || in_taken) begin
            if (pause_sender || pending_bytes.size() == 0) begin
                s_valid <= 1'b0;
            end else if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                s_data <= pending_bytes.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: its own stall pattern, plus a long hold that it times itself.
    int stall_phase;
    int hold_count;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_phase <= 0;
            hold_count <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (hold_receiver) begin
                m_ready <= 1'b0;
                if (hold_count >= HOLD_CYCLES - 1) begin
                    hold_count <= 0;
                    hold_receiver <= 1'b0;
                end else begin
                    hold_count <= hold_count + 1;
                end
            end else if (stall_phase[8:6] == 3'd0) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        mel_pkg::token_t want;
        in_taken <= s_valid && s_ready;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (s_valid && s_ready) begin
                predict_tokens(s_data);
            end
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected", m_data.token_kind, -1);
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_data.token_kind != want.token_kind)
                        report_mismatch("kind", m_data.token_kind, want.token_kind);
                    if (m_data.token_start != want.token_start)
                        report_mismatch("start", m_data.token_start, want.token_start);
                    if (m_data.token_length != want.token_length)
                        report_mismatch("length", m_data.token_length, want.token_length);
                    if (m_data.start_line != want.start_line)
                        report_mismatch("line", m_data.start_line, want.start_line);
                    if (m_data.start_column != want.start_column)
                        report_mismatch("column", m_data.start_column, want.start_column);
                    if (m_data.error_code != want.error_code)
                        report_mismatch("error", m_data.error_code, want.error_code);
                    if (m_data.final_result != want.final_result)
                        report_mismatch("final", m_data.final_result, want.final_result);
                end
                tokens_seen++;
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("timeout: no request moved for %0d cycles", WATCHDOG);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        string s;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        mismatches = 0;
        tokens_seen = 0;
        idle_cycles = 0;
        items_queued = 0;
        hold_receiver = 0;
        pause_sender = 0;
        in_taken = 0;
        lexer_clear();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        queue_text("int diff lim sum prod sqrt x_1", 1);
        queue_text("\xE2\x88\xAB\xE2\x88\x9A\xCF\x80\xCE\xA3\xCE\xA0\xE2\x88\x9E d/dx", 1);
        queue_text("+-*/^%!()[]{},;", 1);
        queue_text("1/0 3/0 4.5 12/34\n\t\r9/0", 1);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_text("5. x", 1);
        queue_text("d/", 1);
        queue_text("\xCE", 1);
        queue_text("a@b", 0);
        queue_byte(8'hFF, 1'b1, 1'b1);
        queue_text("7/", 1);

        // Long receiver hold while the sender keeps offering.
        hold_receiver = 1;
        while (hold_receiver) @(posedge aclk);
        while (pending_bytes.size() != 0) @(posedge aclk);

        // Sender pauses until every expected token has arrived.
        pause_sender = 1;
        while (expected_tokens.size() != 0 || s_valid) @(posedge aclk);
        pause_sender = 0;

        while (items_queued < ITEMS) begin
            s = "";
            for (int w = $urandom_range(1, 3); w > 0; w--)
                s = {s, random_word(), random_glue()};
            if ($urandom_range(0, 5) == 0) begin
                queue_text(s, 0);
                queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
                queue_text(s, 1);
            end
        end
        while (pending_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("covered keywords, UTF-8 symbols, operators, numbers, error recovery");
        $display("and random expressions; %0d tokens checked", tokens_seen);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
